// ===== hdl/mi3_pkg.sv =====
// Package for the 3x3 matrix inverse: Q16.16 constants and arithmetic helpers.
// Depends on nothing; used by mi3_div, matrix_inverse_3x3 and mi3_check.
`timescale 1ns / 1ps
package mi3_pkg;
  localparam int QFRAC = 16;
  localparam int WORD_W = 32;
  // Pipeline depth of the reciprocal divider, one quotient bit per stage.
  localparam int DIV_STAGES = 33;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] prod_t;

  typedef struct packed {
    q_t b00; q_t b01; q_t b02;
    q_t b10; q_t b11; q_t b12;
    q_t b20; q_t b21; q_t b22;
    q_t determinant;
    q_t recip_det;
    logic singular;
  } res_t;

  typedef struct packed {
    q_t a00; q_t a01; q_t a02;
    q_t a10; q_t a11; q_t a12;
    q_t a20; q_t a21; q_t a22;
  } mat_t;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic q_t sat66(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return S32_MAX;
    end else if (v < -66'sd2147483648) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Floor of a product over 2^16, kept at 48 bits.
  function automatic logic signed [47:0] flq(input prod_t p);
    return p[63:16];
  endfunction
endpackage

// ===== hdl/mi3_if.sv =====
// Valid/ready channel interface with a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface mi3_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/mi3_div.sv =====
// Pipelined restoring divider: 2^32 / |det|, one quotient bit per stage.
// Depends on mi3_pkg. Advances only when enabled.
`timescale 1ns / 1ps
module mi3_div (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          den,
  output logic [32:0]          quo
);
  import mi3_pkg::*;
  // Partial remainder, divisor and quotient at each stage.
  logic [32:0] rem [DIV_STAGES+1];
  logic [31:0] dv  [DIV_STAGES+1];
  logic [32:0] qq  [DIV_STAGES+1];

  assign rem[0] = '0;
  assign dv[0]  = den;
  assign qq[0]  = '0;

  // Dividend 2^32 is bit 32 set: feed bit 32 first, zeros after.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [33:0] sh;
    logic [33:0] df;
    logic [32:0] rn;
    logic [32:0] qn;
    always_comb begin
      sh = {rem[s], (s == 0) ? 1'b1 : 1'b0};
      df = sh - {2'b0, dv[s]};
      if (!df[33]) begin
        rn = df[32:0];
        qn = {qq[s][31:0], 1'b1};
      end else begin
        rn = sh[32:0];
        qn = {qq[s][31:0], 1'b0};
      end
    end
    logic [32:0] rr;
    logic [31:0] dr;
    logic [32:0] qr;
    always_ff @(posedge clk) begin
      if (en) begin
        rr <= rn;
        dr <= dv[s];
        qr <= qn;
      end
    end
    assign rem[s+1] = rr;
    assign dv[s+1]  = dr;
    assign qq[s+1]  = qr;
  end
  assign quo = qq[DIV_STAGES];
endmodule

// ===== hdl/matrix_inverse_3x3.sv =====
// channel | role   | payload
// in      | sink   | a00..a22, Q16.16
// out     | source | b00..b22, determinant, recip_det, singular
// One matrix enters per cycle unless the output stalls; the pipe holds the
// 33-stage bit-per-stage reciprocal divider plus 7 arithmetic stages.
// The whole pipe advances when its output slot is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset (rst, synchronous) clears the valid bits only.
// Depends on mi3_pkg, mi3_if and mi3_div.
`timescale 1ns / 1ps
module matrix_inverse_3x3 (
  input logic clk,
  input logic rst,
  mi3_if.sink   in,
  mi3_if.source out
);
  import mi3_pkg::*;
  localparam int NV = 7 + DIV_STAGES;

  logic adv;
  logic [NV-1:0] vld;
  assign adv = !vld[NV-1] || out.ready;
  assign in.ready = adv;
  assign out.valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], in.valid};
    end
  end

  // Stage 1: eighteen products for the adjugate.
  mat_t a1;
  prod_t p1 [18];
  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= in.data;
      p1[0]  <= in.data.a22 * in.data.a11; p1[1]  <= in.data.a21 * in.data.a12;
      p1[2]  <= in.data.a21 * in.data.a02; p1[3]  <= in.data.a22 * in.data.a01;
      p1[4]  <= in.data.a12 * in.data.a01; p1[5]  <= in.data.a11 * in.data.a02;
      p1[6]  <= in.data.a20 * in.data.a12; p1[7]  <= in.data.a22 * in.data.a10;
      p1[8]  <= in.data.a22 * in.data.a00; p1[9]  <= in.data.a20 * in.data.a02;
      p1[10] <= in.data.a10 * in.data.a02; p1[11] <= in.data.a12 * in.data.a00;
      p1[12] <= in.data.a21 * in.data.a10; p1[13] <= in.data.a20 * in.data.a11;
      p1[14] <= in.data.a20 * in.data.a01; p1[15] <= in.data.a21 * in.data.a00;
      p1[16] <= in.data.a11 * in.data.a00; p1[17] <= in.data.a10 * in.data.a01;
    end
  end

  // Stage 2: truncate, subtract and saturate into the adjugate.
  q_t c2 [9];
  q_t a00_2, a10_2, a20_2;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 9; m++) begin
        c2[m] <= sat66(66'(flq(p1[2*m])) - 66'(flq(p1[2*m+1])));
      end
      a00_2 <= a1.a00;
      a10_2 <= a1.a10;
      a20_2 <= a1.a20;
    end
  end

  // Stage 3: determinant products.
  prod_t d3 [3];
  q_t c3 [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      d3[0] <= a00_2 * c2[0];
      d3[1] <= a10_2 * c2[1];
      d3[2] <= a20_2 * c2[2];
      c3 <= c2;
    end
  end

  // Stage 4: sum and saturate the determinant; take its magnitude.
  q_t det4;
  q_t c4 [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      det4 <= sat66(66'(flq(d3[0])) + 66'(flq(d3[1])) + 66'(flq(d3[2])));
      c4 <= c3;
    end
  end
  logic [31:0] mag4;
  assign mag4 = det4[31] ? 32'(-det4) : det4;

  // Divider stages; adjugate and determinant ride alongside.
  logic [32:0] quo;
  mi3_div u_div (.clk(clk), .en(adv), .den(mag4), .quo(quo));

  q_t cd [DIV_STAGES+1][9];
  q_t dd [DIV_STAGES+1];
  always_comb begin
    cd[0] = c4;
    dd[0] = det4;
  end
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        cd[s+1] <= cd[s];
        dd[s+1] <= dd[s];
      end
    end
  end
  q_t cq [9];
  q_t detq;
  assign cq = cd[DIV_STAGES];
  assign detq = dd[DIV_STAGES];

  // Stage 5: signed, saturated reciprocal; zero for a singular matrix.
  q_t rc5, det5;
  q_t c5 [9];
  logic sg5;
  logic signed [34:0] sq;
  always_comb begin
    sq = detq[31] ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sg5 <= (detq == '0);
      det5 <= detq;
      rc5 <= (detq == '0) ? '0 : sat66(66'(sq));
      c5 <= cq;
    end
  end

  // Stage 6: inverse products.
  prod_t p6 [9];
  q_t rc6, det6;
  logic sg6;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 9; m++) begin
        p6[m] <= c5[m] * rc5;
      end
      rc6 <= rc5;
      det6 <= det5;
      sg6 <= sg5;
    end
  end

  // Stage 7: truncate and saturate into the result register.
  res_t r7;
  q_t b7 [9];
  always_comb begin
    for (int m = 0; m < 9; m++) begin
      b7[m] = sat66(66'(flq(p6[m])));
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r7 <= '{b7[0], b7[1], b7[2], b7[3], b7[4], b7[5], b7[6], b7[7], b7[8],
              det6, rc6, sg6};
    end
  end
  assign out.data = r7;
endmodule

// ===== hdl/mi3_check.sv =====
// Port-level checks for the matrix inverse, bound to the top level.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input mi3_pkg::res_t res
);
  import mi3_pkg::*;
  // A singular result carries zero reciprocal and determinant.
  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.singular |-> res.recip_det == '0 && res.determinant == '0)
    else $error("singular result with nonzero fields");
  // A nonsingular result has a nonzero determinant.
  a_nons: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.singular |-> res.determinant != '0)
    else $error("nonsingular result with zero determinant");
  // Input is ready whenever the output is not stalled.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked without an output stall");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("stalled result changed");
endmodule

bind matrix_inverse_3x3 mi3_check u_chk (
  .clk(clk), .rst(rst), .in_ready(in.ready), .out_valid(out.valid),
  .out_ready(out.ready), .res(out.data)
);
